/* rtl/core/tcpid_pkg.sv */
// Package: shared types, constants and register codes for the cascaded PID core.
`timescale 1ns / 1ps
package tcpid_pkg;

	localparam int POSITION_DIVIDE_DEF = 25;
	localparam int VELOCITY_DIVIDE_DEF = 5;
	localparam int ROTOR_PAIRS_DEF     = 7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_GAINS = 3'd0,
		REG_VEL_GAINS = 3'd1,
		REG_CUR_GAINS = 3'd2,
		REG_POS_LIMIT = 3'd3,
		REG_VEL_LIMIT = 3'd4,
		REG_CUR_LIMIT = 3'd5,
		REG_ANG_OFFS  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] target_position;
		logic signed [31:0] actual_position;
		logic               position_valid;
		logic signed [31:0] actual_speed;
		logic signed [31:0] actual_current;
		logic        [15:0] mech_angle;
		logic               angle_valid;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] voltage_q;
		logic        [15:0] elec_angle;
		logic signed [31:0] speed_reference;
		logic signed [31:0] current_reference;
	} out_word_t;

	// one PID job handed to the shared unit
	typedef struct packed {
		logic               start;
		logic        [47:0] gains;
		logic signed [32:0] err_raw;
		logic signed [31:0] integ;
		logic signed [31:0] last;
		logic        [30:0] int_lim;
		logic        [30:0] out_lim;
	} pid_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] integ;
		logic signed [31:0] last;
		logic signed [31:0] result;
	} pid_rsp_t;

	function automatic logic signed [33:0] clamp_mag(input logic signed [33:0] v,
		input logic [30:0] lim);
		logic signed [33:0] l;
		l = $signed({3'b000, lim});
		if (v > l) return l;
		if (v < -l) return -l;
		return v;
	endfunction

endpackage

/* rtl/core/triple_cascade_pid_motor_control_core.sv */
// Top level: cascaded position / velocity / current PID with electrical angle.
`timescale 1ns / 1ps
// One control word in, one result word out. A tick runs up to three PIDs in
// turn on a single shared multiplier unit, each started from T_POS, T_VEL
// or T_CUR and awaited in T_WAIT; stall is high from accept until the result
// word is taken. The position loop runs on every POSITION_DIVIDE-th word
// (only if position_valid), the velocity loop on every VELOCITY_DIVIDE-th,
// the current loop always. The electrical angle
// ((mech_angle + angle_offset) * ROTOR_PAIRS) mod 65536 is held when
// angle_valid is low. Gains are Q8.8 (kp 15:0, ki 31:16, kd 47:32), signals
// Q16.16; a limit of zero forces the integral and output to zero. Writes to
// unlisted register indexes are dropped. All state but w_q resets to zero.
module triple_cascade_pid_motor_control_core
	import tcpid_pkg::*;
#(
	parameter int POSITION_DIVIDE = POSITION_DIVIDE_DEF,
	parameter int VELOCITY_DIVIDE = VELOCITY_DIVIDE_DEF,
	parameter int ROTOR_PAIRS     = ROTOR_PAIRS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_word,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SC_W = $clog2(POSITION_DIVIDE + 1);
	localparam int MC_W = $clog2(VELOCITY_DIVIDE + 1);
	localparam int PP_W = $clog2(ROTOR_PAIRS + 1);

	typedef enum logic [2:0] {T_IDLE, T_POS, T_VEL, T_CUR, T_WAIT, T_OUT} tst_t;

	// config
	logic [47:0] pos_g_q, vel_g_q, cur_g_q;
	logic [30:0] pos_l_q, vel_l_q, cur_l_q;
	logic [15:0] ang_off_q;

	// loop state
	tst_t               st_q, wait_nxt_q;
	logic [SC_W-1:0]    slow_q;
	logic [MC_W-1:0]    mid_q;
	logic signed [31:0] sref_q, cref_q;
	logic signed [31:0] pi_q, pe_q, vi_q, ve_q, ci_q, ce_q;
	logic signed [31:0] vq_q;
	logic        [15:0] ang_q;
	in_word_t           w_q;

	pid_req_t req;
	pid_rsp_t rsp;

	logic [15:0] ang_sum;
	logic [15:0] ang_mul;

	assign ang_sum = w_q.mech_angle + ang_off_q;
	assign ang_mul = 16'(ang_sum * PP_W'(ROTOR_PAIRS));

	tcpid_pid_unit u_pid (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always_comb begin
		req = '0;
		unique case (st_q)
			T_POS: begin
				req.start   = 1'b1;
				req.gains   = pos_g_q;
				req.err_raw = 33'(w_q.target_position) - 33'(w_q.actual_position);
				req.integ   = pi_q;
				req.last    = pe_q;
				req.int_lim = pos_l_q;
				req.out_lim = vel_l_q;
			end
			T_VEL: begin
				req.start   = 1'b1;
				req.gains   = vel_g_q;
				req.err_raw = 33'(sref_q) - 33'(w_q.actual_speed);
				req.integ   = vi_q;
				req.last    = ve_q;
				req.int_lim = vel_l_q;
				req.out_lim = cur_l_q;
			end
			T_CUR: begin
				req.start   = 1'b1;
				req.gains   = cur_g_q;
				req.err_raw = 33'(cref_q) - 33'(w_q.actual_current);
				req.integ   = ci_q;
				req.last    = ce_q;
				req.int_lim = cur_l_q;
				req.out_lim = cur_l_q;
			end
			default: ;
		endcase
	end

	assign in_stall  = (st_q != T_IDLE);
	assign out_valid = (st_q == T_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_g_q <= '0; vel_g_q <= '0; cur_g_q <= '0;
			pos_l_q <= '0; vel_l_q <= '0; cur_l_q <= '0;
			ang_off_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POS_GAINS: pos_g_q <= cfg_data;
				REG_VEL_GAINS: vel_g_q <= cfg_data;
				REG_CUR_GAINS: cur_g_q <= cfg_data;
				REG_POS_LIMIT: pos_l_q <= cfg_data[30:0];
				REG_VEL_LIMIT: vel_l_q <= cfg_data[30:0];
				REG_CUR_LIMIT: cur_l_q <= cfg_data[30:0];
				REG_ANG_OFFS:  ang_off_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE; wait_nxt_q <= T_IDLE;
			slow_q <= '0; mid_q <= '0;
			sref_q <= '0; cref_q <= '0;
			pi_q <= '0; pe_q <= '0; vi_q <= '0; ve_q <= '0; ci_q <= '0; ce_q <= '0;
			vq_q <= '0;
			ang_q <= '0;
		end else begin
			unique case (st_q)
				T_IDLE: if (in_valid) begin
					w_q <= in_word;
					if (slow_q == '0 && in_word.position_valid) st_q <= T_POS;
					else if (mid_q == '0) st_q <= T_VEL;
					else st_q <= T_CUR;
				end
				T_POS: begin wait_nxt_q <= T_POS; st_q <= T_WAIT; end
				T_VEL: begin wait_nxt_q <= T_VEL; st_q <= T_WAIT; end
				T_CUR: begin wait_nxt_q <= T_CUR; st_q <= T_WAIT; end
				T_WAIT: if (rsp.done) begin
					// wait_nxt_q names the loop just finished
					case (wait_nxt_q)
						T_POS: begin
							pi_q <= rsp.integ; pe_q <= rsp.last; sref_q <= rsp.result;
							st_q <= (mid_q == '0) ? T_VEL : T_CUR;
						end
						T_VEL: begin
							vi_q <= rsp.integ; ve_q <= rsp.last; cref_q <= rsp.result;
							st_q <= T_CUR;
						end
						default: begin
							ci_q <= rsp.integ; ce_q <= rsp.last;
							vq_q <= rsp.result;
							if (w_q.angle_valid) ang_q <= ang_mul;
							mid_q  <= (32'(mid_q) + 1 >= VELOCITY_DIVIDE) ? '0 : mid_q + 1'b1;
							slow_q <= (32'(slow_q) + 1 >= POSITION_DIVIDE) ? '0 : slow_q + 1'b1;
							st_q <= T_OUT;
						end
					endcase
				end
				T_OUT: if (!out_stall) st_q <= T_IDLE;
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign out_word.voltage_q         = vq_q;
	assign out_word.elec_angle        = ang_q;
	assign out_word.speed_reference   = sref_q;
	assign out_word.current_reference = cref_q;

endmodule

/* rtl/core/tcpid_pid_unit.sv */
// Shared PID unit: one 16x34 multiplier stepped over kp, ki and kd terms.
`timescale 1ns / 1ps
module tcpid_pid_unit
	import tcpid_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  pid_req_t req,
	output pid_rsp_t rsp
);

	typedef enum logic [2:0] {S_IDLE, S_PREP, S_KP, S_KI, S_KD, S_OUT} st_t;

	st_t                st_q;
	logic signed [31:0] e_q, i_q;
	logic signed [32:0] d_q;
	logic signed [52:0] acc_q;
	logic        [47:0] g_q;
	logic        [30:0] olim_q;
	logic signed [49:0] prod_q;

	logic signed [33:0] e_sat, i_new;
	logic signed [15:0] gsel;
	logic signed [33:0] osel;
	logic signed [52:0] shifted;
	logic signed [33:0] out_c;

	always_comb begin
		e_sat = $signed({req.err_raw[32], req.err_raw});
		if (e_sat > 34'sd2147483647) e_sat = 34'sd2147483647;
		else if (e_sat < -34'sd2147483648) e_sat = -34'sd2147483648;
		i_new = clamp_mag($signed({{2{req.integ[31]}}, req.integ}) + e_sat, req.int_lim);
		gsel = $signed(g_q[15:0]);
		osel = $signed({{2{e_q[31]}}, e_q});
		case (st_q)
			S_KI: begin
				gsel = $signed(g_q[31:16]);
				osel = $signed({{2{i_q[31]}}, i_q});
			end
			S_KD: begin
				gsel = $signed(g_q[47:32]);
				osel = $signed({d_q[32], d_q});
			end
			default: ;
		endcase
		shifted = (acc_q + $signed({{3{prod_q[49]}}, prod_q})) >>> 8;
		out_c = clamp_mag(shifted[33:0], olim_q);
		if (shifted > 53'sd4294967295 || shifted < -53'sd4294967296)
			out_c = shifted[52] ? -$signed({3'b000, olim_q}) : $signed({3'b000, olim_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			rsp.done <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (req.start) begin
					e_q    <= e_sat[31:0];
					i_q    <= i_new[31:0];
					d_q    <= 33'(e_sat - $signed({{2{req.last[31]}}, req.last}));
					g_q    <= req.gains;
					olim_q <= req.out_lim;
					acc_q  <= '0;
					st_q   <= S_PREP;
				end
				S_PREP: st_q <= S_KP;
				S_KP: begin
					prod_q <= gsel * osel;
					st_q   <= S_KI;
				end
				S_KI: begin
					acc_q  <= acc_q + $signed({{3{prod_q[49]}}, prod_q});
					prod_q <= gsel * osel;
					st_q   <= S_KD;
				end
				S_KD: begin
					acc_q  <= acc_q + $signed({{3{prod_q[49]}}, prod_q});
					prod_q <= gsel * osel;
					st_q   <= S_OUT;
				end
				S_OUT: begin
					rsp.result <= out_c[31:0];
					rsp.integ  <= i_q;
					rsp.last   <= e_q;
					rsp.done   <= 1'b1;
					st_q       <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* dv/tb_triple_cascade_pid_motor_control_core.sv */
// Testbench: cascaded PID motor control core against a cycle-free software predictor.
`timescale 1ns / 1ps
module tb_triple_cascade_pid_motor_control_core;
	import tcpid_pkg::*;

	localparam int POS_DIV = POSITION_DIVIDE_DEF;
	localparam int VEL_DIV = VELOCITY_DIVIDE_DEF;
	localparam int POLES   = ROTOR_PAIRS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	triple_cascade_pid_motor_control_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor copy of the registers
	logic [47:0] m_pos_gains, m_vel_gains, m_cur_gains;
	logic [30:0] m_pos_lim, m_vel_lim, m_cur_lim;
	logic [15:0] m_ang_offs;
	// predictor copy of the loop state
	int unsigned m_slow, m_mid;
	logic signed [31:0] m_speed_ref, m_cur_ref;
	logic signed [31:0] m_pos_i, m_pos_e, m_vel_i, m_vel_e, m_cur_i, m_cur_e;
	logic [15:0] m_angle;

	in_word_t  pending_words[$];
	out_word_t expected_results[$];
	int errors = 0;
	int burst_left = 0;
	int gap_left = 0;

	function automatic longint clamp_to(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// one PID update: exact sum of Q8.8 x Q16.16 products, floor >> 8, clamp
	function automatic logic signed [31:0] pid_update(input logic [47:0] gains,
		input longint err_raw, inout logic signed [31:0] integ,
		inout logic signed [31:0] last, input logic [30:0] ilim,
		input logic [30:0] olim);
		longint kp, ki, kd, e, i, d, acc;
		kp = longint'($signed(gains[15:0]));
		ki = longint'($signed(gains[31:16]));
		kd = longint'($signed(gains[47:32]));
		e = err_raw;
		if (e > 64'sd2147483647) e = 64'sd2147483647;
		if (e < -64'sd2147483648) e = -64'sd2147483648;
		i = clamp_to(longint'(integ) + e, longint'({33'd0, ilim}));
		d = e - longint'(last);
		acc = kp * e + ki * i + kd * d;
		integ = i[31:0];
		last = e[31:0];
		return 32'(clamp_to(acc >>> 8, longint'({33'd0, olim})));
	endfunction

	task automatic predict_tick(input in_word_t w);
		out_word_t r;
		logic [15:0] a;
		if (m_slow == 0 && w.position_valid)
			m_speed_ref = pid_update(m_pos_gains,
				longint'(w.target_position) - longint'(w.actual_position),
				m_pos_i, m_pos_e, m_pos_lim, m_vel_lim);
		if (m_mid == 0)
			m_cur_ref = pid_update(m_vel_gains,
				longint'(m_speed_ref) - longint'(w.actual_speed),
				m_vel_i, m_vel_e, m_vel_lim, m_cur_lim);
		r.voltage_q = pid_update(m_cur_gains,
			longint'(m_cur_ref) - longint'(w.actual_current),
			m_cur_i, m_cur_e, m_cur_lim, m_cur_lim);
		if (w.angle_valid) begin
			a = w.mech_angle + m_ang_offs;
			m_angle = 16'(32'(a) * POLES);
		end
		m_mid = (m_mid + 1 >= VEL_DIV) ? 0 : m_mid + 1;
		m_slow = (m_slow + 1 >= POS_DIV) ? 0 : m_slow + 1;
		r.elec_angle = m_angle;
		r.speed_reference = m_speed_ref;
		r.current_reference = m_cur_ref;
		expected_results.push_back(r);
	endtask

	// driver: bursts of words with random gaps; payload held while stalled
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_tick(in_word);
		end
		if (!(in_valid && in_stall)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0 && arst_n) begin
				in_word <= pending_words.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 0) begin
					burst_left <= $urandom_range(1, 12);
					if ($urandom_range(0, 3) != 0)
						gap_left <= $urandom_range(0, 40);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern: random-length runs, each with random stalls or with no stall
	int stall_run = 0;
	bit stall_mode = 1'b0;
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode <= ($urandom_range(0, 2) == 0);
			stall_run <= $urandom_range(1, 30);
			out_stall <= 1'b0;
		end else begin
			stall_run <= stall_run - 1;
			out_stall <= stall_mode ? ($urandom_range(0, 1) == 1) : 1'b0;
		end
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result word with no prediction pending: %h", out_word);
				errors++;
			end else begin
				exp_w = expected_results.pop_front();
				if (out_word.voltage_q !== exp_w.voltage_q) begin
					$error("voltage_q exp %0d got %0d", exp_w.voltage_q, out_word.voltage_q);
					errors++;
				end
				if (out_word.elec_angle !== exp_w.elec_angle) begin
					$error("elec_angle exp %0d got %0d", exp_w.elec_angle, out_word.elec_angle);
					errors++;
				end
				if (out_word.speed_reference !== exp_w.speed_reference) begin
					$error("speed_reference exp %0d got %0d", exp_w.speed_reference,
						out_word.speed_reference);
					errors++;
				end
				if (out_word.current_reference !== exp_w.current_reference) begin
					$error("current_reference exp %0d got %0d", exp_w.current_reference,
						out_word.current_reference);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [47:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_POS_GAINS: m_pos_gains = v;
			REG_VEL_GAINS: m_vel_gains = v;
			REG_CUR_GAINS: m_cur_gains = v;
			REG_POS_LIMIT: m_pos_lim = v[30:0];
			REG_VEL_LIMIT: m_vel_lim = v[30:0];
			REG_CUR_LIMIT: m_cur_lim = v[30:0];
			REG_ANG_OFFS:  m_ang_offs = v[15:0];
			default: ;
		endcase
	endtask

	// block idle: nothing queued, nothing in flight, then a latency margin
	task automatic drain();
		wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_sig();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 65535 * 4) - 32'sd131072;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [47:0] rand_gains(input int mode);
		logic [47:0] g;
		g = 48'({$urandom(), $urandom()});
		if (mode == 1) begin
			g[15:0] = 16'($urandom_range(0, 600) - 300);
			g[31:16] = 16'($urandom_range(0, 64) - 32);
			g[47:32] = 16'($urandom_range(0, 128) - 64);
		end
		return g;
	endfunction

	function automatic in_word_t rand_word(input bit tracking);
		in_word_t w;
		w.target_position = rand_sig();
		w.actual_position = tracking ? w.target_position - ($urandom_range(0, 200000)
			- 100000) : rand_sig();
		w.position_valid = ($urandom_range(0, 7) != 0);
		w.actual_speed = rand_sig();
		w.actual_current = rand_sig();
		w.mech_angle = 16'($urandom());
		w.angle_valid = ($urandom_range(0, 5) != 0);
		return w;
	endfunction

	task automatic load_limits(input logic [30:0] pl, input logic [30:0] vl,
		input logic [30:0] cl);
		write_reg(REG_POS_LIMIT, {17'd0, pl});
		write_reg(REG_VEL_LIMIT, {17'd0, vl});
		write_reg(REG_CUR_LIMIT, {17'd0, cl});
	endtask

	initial begin
		in_word_t w;
		m_pos_gains = '0; m_vel_gains = '0; m_cur_gains = '0;
		m_pos_lim = '0; m_vel_lim = '0; m_cur_lim = '0; m_ang_offs = '0;
		m_slow = 0; m_mid = 0; m_speed_ref = '0; m_cur_ref = '0;
		m_pos_i = '0; m_pos_e = '0; m_vel_i = '0; m_vel_e = '0;
		m_cur_i = '0; m_cur_e = '0; m_angle = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all limits zero first (integral and output forced to zero)
		w = '0;
		w.target_position = 32'sh7FFF_FFFF; w.actual_position = 32'sh8000_0000;
		w.position_valid = 1'b1; w.angle_valid = 1'b1; w.mech_angle = 16'hFFFF;
		pending_words.push_back(w);
		drain();

		// extremes: full gains and full limits, saturating errors both ways
		write_reg(REG_POS_GAINS, 48'h7FFF_7FFF_7FFF);
		write_reg(REG_VEL_GAINS, 48'h8000_8000_8000);
		write_reg(REG_CUR_GAINS, 48'hFFFF_0001_7FFF);
		load_limits(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		write_reg(REG_ANG_OFFS, 48'hFFFF);
		for (int k = 0; k < 22; k++) begin
			w = rand_word(1'b0);
			w.target_position = k[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			w.actual_position = k[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			w.actual_speed = k[1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			w.actual_current = k[2] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			w.mech_angle = k[0] ? 16'hFFFF : 16'h0000;
			w.position_valid = (k % 3 != 1);  // position read failure on some ticks
			w.angle_valid = (k % 4 != 3);     // angle read failure holds the angle
			pending_words.push_back(w);
		end
		drain();

		// random phases across several register settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_POS_GAINS, rand_gains(ph % 2));
			write_reg(REG_VEL_GAINS, rand_gains(ph % 2));
			write_reg(REG_CUR_GAINS, rand_gains(ph % 2));
			case (ph % 4)
				0: load_limits(31'($urandom()), 31'($urandom()), 31'($urandom()));
				1: load_limits(31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 18)),
					31'($urandom_range(0, 1 << 16)));
				2: load_limits(31'd0, 31'($urandom_range(1, 5)), 31'd1);
				default: load_limits(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
			endcase
			write_reg(REG_ANG_OFFS, 48'($urandom_range(0, 65535)));
			for (int k = 0; k < 100; k++)
				pending_words.push_back(rand_word($urandom_range(0, 3) != 0));
			drain();
		end
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
